// ===== hw/rtl/tcfd_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table for the tilt filter drive.
package tcfd_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_X_OFFSET      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_Y_OFFSET      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_Z_OFFSET      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GYRO_Y_OFFSET       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BLEND_ALPHA         = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_WHEN_POSITIVE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_WHEN_NEGATIVE = 3'd6;

	localparam logic [15:0] ALPHA_RESET     = 16'd32113;
	localparam logic [31:0] SPEED_POS_RESET = 32'hFFFF_0000;
	localparam logic [31:0] SPEED_NEG_RESET = 32'h2211_0000;

	localparam int QUEUE_DEPTH  = 2;
	localparam int ATAN_ENTRIES = 24;
	localparam int STEP_W       = 5;

	localparam logic [STEP_W-1:0] SQRT_TOP = 5'd16;

	localparam logic [14:0] RECIP_131  = 15'd32018;
	localparam logic [23:0] RECIP_250  = 24'd8589935;
	localparam logic [42:0] ROUND_HALF = 43'd4096000;

	localparam logic [15:0] ALPHA_ONE   = 16'd32768;
	localparam logic [15:0] PITCH_LIMIT = 16'd23040;
	localparam logic signed [15:0] RATE_MAX = 16'sh7FFF;
	localparam logic signed [15:0] RATE_MIN = 16'sh8000;

	localparam logic [7:0] FRAME_CMD = 8'hA2;

	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_POS  = 2'd1;
	localparam logic [1:0] DIR_NEG  = 2'd2;

	typedef struct packed {
		logic signed [16:0] ax;
		logic [32:0]        sq;
		logic signed [15:0] rate;
		logic               ax_zero;
	} tcfd_item_t;

	typedef struct packed {
		logic [15:0] ax_off;
		logic [15:0] ay_off;
		logic [15:0] az_off;
		logic [15:0] gy_off;
	} tcfd_offsets_t;

	typedef struct packed {
		logic [15:0] alpha;
		logic [31:0] spd_pos;
		logic [31:0] spd_neg;
	} tcfd_drive_cfg_t;

	// atan(2^-i) in 1/65536 degree.
	function automatic logic [21:0] atan_step(input logic [STEP_W-1:0] idx);
		logic [21:0] v;
		case (idx)
			5'd0: v = 22'd2949120;
			5'd1: v = 22'd1740967;
			5'd2: v = 22'd919879;
			5'd3: v = 22'd466945;
			5'd4: v = 22'd234379;
			5'd5: v = 22'd117304;
			5'd6: v = 22'd58666;
			5'd7: v = 22'd29335;
			5'd8: v = 22'd14668;
			5'd9: v = 22'd7334;
			5'd10: v = 22'd3667;
			5'd11: v = 22'd1833;
			5'd12: v = 22'd917;
			5'd13: v = 22'd458;
			5'd14: v = 22'd229;
			5'd15: v = 22'd115;
			5'd16: v = 22'd57;
			5'd17: v = 22'd29;
			5'd18: v = 22'd14;
			5'd19: v = 22'd7;
			5'd20: v = 22'd4;
			5'd21: v = 22'd2;
			5'd22: v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== hw/rtl/tilt_complementary_filter_drive.sv =====
// Top level of the tilt complementary filter drive: configuration registers and block wiring.
// The back sequencer takes one item at a time through its square root and CORDIC iterations
// and pops no new item until it has loaded the last result into the output registers;
// the four-stage front and two-entry queue absorb stalls.
// Reset clears the kept pitch, the queue and all valid flags, and loads the register defaults.
module tilt_complementary_filter_drive #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [15:0]              accel_x,
	input  logic signed [15:0]              accel_y,
	input  logic signed [15:0]              accel_z,
	input  logic signed [15:0]              gyro_y,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [15:0]              pitch_angle,
	output logic signed [15:0]              tilt_rate,
	output logic [1:0]                      drive_direction,
	output logic [63:0]                     command_payload,
	input  logic                            cfg_we,
	input  logic [tcfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tcfd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tcfd_pkg::*;

	tcfd_offsets_t   offsets_q;
	tcfd_drive_cfg_t drive_cfg_q;

	logic       push, full, pop_valid, pop;
	tcfd_item_t push_item, pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offsets_q           <= '0;
			drive_cfg_q.alpha   <= ALPHA_RESET;
			drive_cfg_q.spd_pos <= SPEED_POS_RESET;
			drive_cfg_q.spd_neg <= SPEED_NEG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ACCEL_X_OFFSET:      offsets_q.ax_off      <= cfg_data[15:0];
				REG_ACCEL_Y_OFFSET:      offsets_q.ay_off      <= cfg_data[15:0];
				REG_ACCEL_Z_OFFSET:      offsets_q.az_off      <= cfg_data[15:0];
				REG_GYRO_Y_OFFSET:       offsets_q.gy_off      <= cfg_data[15:0];
				REG_BLEND_ALPHA:         drive_cfg_q.alpha     <= cfg_data[15:0];
				REG_SPEED_WHEN_POSITIVE: drive_cfg_q.spd_pos   <= cfg_data;
				REG_SPEED_WHEN_NEGATIVE: drive_cfg_q.spd_neg   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	tcfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.accel_x   (accel_x),
		.accel_y   (accel_y),
		.accel_z   (accel_z),
		.gyro_y    (gyro_y),
		.offsets   (offsets_q),
		.push      (push),
		.push_item (push_item),
		.full      (full)
	);

	tcfd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_item  (pop_item)
	);

	tcfd_back #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.pop_valid       (pop_valid),
		.pop             (pop),
		.pop_item        (pop_item),
		.cfg             (drive_cfg_q),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.pitch_angle     (pitch_angle),
		.tilt_rate       (tilt_rate),
		.drive_direction (drive_direction),
		.command_payload (command_payload)
	);

endmodule

// ===== hw/rtl/tcfd_front.sv =====
// Front pipeline: offset removal, squared magnitude, gyro rate by reciprocal divide.
module tcfd_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [15:0]     accel_x,
	input  logic signed [15:0]     accel_y,
	input  logic signed [15:0]     accel_z,
	input  logic signed [15:0]     gyro_y,
	input  tcfd_pkg::tcfd_offsets_t offsets,
	output logic                   push,
	output tcfd_pkg::tcfd_item_t   push_item,
	input  logic                   full
);
	import tcfd_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv;

	logic signed [16:0] ax_s1, ay_s1, az_s1, gy_s1;
	logic signed [16:0] ax_s2, ax_s3;
	logic [31:0]        ay2_s2, az2_s2;
	logic [22:0]        n_s2, n_s3;
	logic               gneg_s2, gneg_s3;
	logic [32:0]        sq_s3;
	logic [15:0]        qe_s3;
	tcfd_item_t         item_s4;

	logic signed [33:0] ay_sq_w, az_sq_w;
	logic [15:0]        gy_mag_w;
	logic [37:0]        recip_w;
	logic [23:0]        chk_w;
	logic [15:0]        q_w;
	logic signed [15:0] rate_w;

	assign adv       = !v_s4 || !full;
	assign in_ready  = adv;
	assign push      = v_s4 && !full;
	assign push_item = item_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign ay_sq_w  = ay_s1 * ay_s1;
	assign az_sq_w  = az_s1 * az_s1;
	assign gy_mag_w = gy_s1[16] ? 16'(-gy_s1) : gy_s1[15:0];
	assign recip_w  = 38'(n_s2) * 38'(RECIP_131);

	// The reciprocal estimate is the true quotient or one above it.
	always_comb begin
		chk_w = 24'(qe_s3) * 24'd131;
		q_w   = ({1'b0, n_s3} < chk_w) ? qe_s3 - 16'd1 : qe_s3;
		if (gneg_s3) begin
			rate_w = (q_w > ALPHA_ONE) ? RATE_MIN : 16'(-q_w);
		end else begin
			rate_w = (q_w > 16'(RATE_MAX)) ? RATE_MAX : q_w;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (in_valid) begin
				ax_s1 <= {accel_x[15], accel_x} - {offsets.ax_off[15], offsets.ax_off};
				ay_s1 <= {accel_y[15], accel_y} - {offsets.ay_off[15], offsets.ay_off};
				az_s1 <= {accel_z[15], accel_z} - {offsets.az_off[15], offsets.az_off};
				gy_s1 <= {gyro_y[15], gyro_y} - {offsets.gy_off[15], offsets.gy_off};
			end
			ax_s2   <= ax_s1;
			ay2_s2  <= ay_sq_w[31:0];
			az2_s2  <= az_sq_w[31:0];
			n_s2    <= {gy_mag_w, 7'b0} + 23'd65;
			gneg_s2 <= gy_s1[16];

			ax_s3   <= ax_s2;
			sq_s3   <= {1'b0, ay2_s2} + {1'b0, az2_s2};
			qe_s3   <= recip_w[37:22];
			n_s3    <= n_s2;
			gneg_s3 <= gneg_s2;

			item_s4.ax      <= ax_s3;
			item_s4.sq      <= sq_s3;
			item_s4.rate    <= rate_w;
			item_s4.ax_zero <= (ax_s3 == 17'sd0);
		end
	end

endmodule

// ===== hw/rtl/tcfd_fifo.sv =====
// Short item queue between the front pipeline and the back sequencer.
module tcfd_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  tcfd_pkg::tcfd_item_t push_item,
	output logic                 full,
	output logic                 pop_valid,
	input  logic                 pop,
	output tcfd_pkg::tcfd_item_t pop_item
);
	import tcfd_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	tcfd_item_t       mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full      = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> pop_valid)
		else $error("pop from an empty queue");

endmodule

// ===== hw/rtl/tcfd_back.sv =====
// Back sequencer: square root, CORDIC atan2, complementary blend and motor frame output.
module tcfd_back #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     pop_valid,
	output logic                     pop,
	input  tcfd_pkg::tcfd_item_t     pop_item,
	input  tcfd_pkg::tcfd_drive_cfg_t cfg,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [15:0]       pitch_angle,
	output logic signed [15:0]       tilt_rate,
	output logic [1:0]               drive_direction,
	output logic [63:0]              command_payload
);
	import tcfd_pkg::*;

	localparam int STEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b00_0000_0001,
		ST_SQRT   = 10'b00_0000_0010,
		ST_CORDIC = 10'b00_0000_0100,
		ST_PREP   = 10'b00_0000_1000,
		ST_MULA   = 10'b00_0001_0000,
		ST_MULB   = 10'b00_0010_0000,
		ST_DIVE   = 10'b00_0100_0000,
		ST_DIVM   = 10'b00_1000_0000,
		ST_DIVF   = 10'b01_0000_0000,
		ST_OUT    = 10'b10_0000_0000
	} state_t;

	state_t              st_q;
	logic [STEP_W-1:0]   cnt_q;
	logic signed [15:0]  pe_q;
	logic                out_valid_q;

	logic signed [16:0]  ax_q;
	logic signed [15:0]  rate_q;
	logic                ax_zero_q;
	logic [32:0]         v_q;
	logic [33:0]         res_q;
	logic signed [27:0]  x_q, y_q;
	logic signed [24:0]  z_q;
	logic signed [24:0]  t1_q, t2_q;
	logic signed [42:0]  pa_q, num_q;
	logic [22:0]         s_q;
	logic                neg_q;
	logic [15:0]         qe_q;
	logic signed [15:0]  p_q;
	logic signed [15:0]  pitch_q, rate_out_q;
	logic [1:0]          dir_q;
	logic [63:0]         payload_q;

	logic [32:0]         sq_bit_w;
	logic [34:0]         sq_trial_w;
	logic [32:0]         v_nxt_w;
	logic [33:0]         res_nxt_w;
	logic signed [27:0]  xs_w, ys_w;
	logic signed [24:0]  at_w, zsum_w;
	logic signed [15:0]  acc_w;
	logic [15:0]         a_w;
	logic signed [16:0]  a17_w, b17_w;
	logic [42:0]         mag_w;
	logic [46:0]         recip_w;
	logic [23:0]         chk_w;
	logic [15:0]         q_w, qc_w;
	logic                load_out;

	assign pop       = (st_q == ST_IDLE) && pop_valid;
	assign load_out  = (st_q == ST_OUT) && (!out_valid_q || out_ready);

	assign out_valid       = out_valid_q;
	assign pitch_angle     = pitch_q;
	assign tilt_rate       = rate_out_q;
	assign drive_direction = dir_q;
	assign command_payload = payload_q;

	// Restoring square root, one result bit per cycle.
	always_comb begin
		sq_bit_w   = 33'd1 << {cnt_q, 1'b0};
		sq_trial_w = {1'b0, res_q} + {2'b0, sq_bit_w};
		if ({2'b0, v_q} >= sq_trial_w) begin
			v_nxt_w   = v_q - sq_trial_w[32:0];
			res_nxt_w = {1'b0, res_q[33:1]} + {1'b0, sq_bit_w};
		end else begin
			v_nxt_w   = v_q;
			res_nxt_w = {1'b0, res_q[33:1]};
		end
	end

	assign xs_w   = x_q >>> cnt_q;
	assign ys_w   = y_q >>> cnt_q;
	assign at_w   = signed'({3'b0, atan_step(cnt_q)});
	assign zsum_w = z_q + 25'sd256;
	assign acc_w  = ax_zero_q ? 16'sd0 : zsum_w[24:9];

	assign a_w   = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
	assign a17_w = signed'({1'b0, a_w});
	assign b17_w = signed'({1'b0, ALPHA_ONE}) - a17_w;

	assign mag_w   = (num_q[42] ? 43'(-num_q) : 43'(num_q)) + ROUND_HALF;
	assign recip_w = 47'(s_q) * 47'(RECIP_250);

	// The reciprocal estimate is the true quotient or one above it.
	always_comb begin
		chk_w = 24'(qe_q) * 24'd250;
		q_w   = ({1'b0, s_q} < chk_w) ? qe_q - 16'd1 : qe_q;
		qc_w  = (q_w > PITCH_LIMIT) ? PITCH_LIMIT : q_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			cnt_q       <= '0;
			pe_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
				pe_q        <= p_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (pop_valid) begin
						cnt_q <= SQRT_TOP;
						st_q  <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (cnt_q == '0) begin
						st_q <= ST_CORDIC;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_CORDIC: begin
					if (cnt_q == STEP_W'(STEPS - 1)) begin
						cnt_q <= '0;
						st_q  <= ST_PREP;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_PREP: st_q <= ST_MULA;
				ST_MULA: st_q <= ST_MULB;
				ST_MULB: st_q <= ST_DIVE;
				ST_DIVE: st_q <= ST_DIVM;
				ST_DIVM: st_q <= ST_DIVF;
				ST_DIVF: st_q <= ST_OUT;
				ST_OUT: begin
					if (load_out) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				ax_q      <= pop_item.ax;
				rate_q    <= pop_item.rate;
				ax_zero_q <= pop_item.ax_zero;
				v_q       <= pop_item.sq;
				res_q     <= '0;
			end
			ST_SQRT: begin
				v_q   <= v_nxt_w;
				res_q <= res_nxt_w;
				x_q   <= signed'({3'b0, res_nxt_w[16:0], 8'b0});
				y_q   <= {{3{ax_q[16]}}, ax_q, 8'b0};
				z_q   <= '0;
			end
			ST_CORDIC: begin
				if (y_q > 28'sd0) begin
					x_q <= x_q + ys_w;
					y_q <= y_q - xs_w;
					z_q <= z_q + at_w;
				end else begin
					x_q <= x_q - ys_w;
					y_q <= y_q + xs_w;
					z_q <= z_q - at_w;
				end
			end
			ST_PREP: begin
				t1_q <= (25'(pe_q) * 25'sd250) + 25'(rate_q);
				t2_q <= 25'(acc_w) * 25'sd250;
			end
			ST_MULA: pa_q <= a17_w * t1_q;
			ST_MULB: num_q <= pa_q + b17_w * t2_q;
			ST_DIVE: begin
				s_q   <= mag_w[37:15];
				neg_q <= num_q[42];
			end
			ST_DIVM: qe_q <= recip_w[46:31];
			ST_DIVF: p_q <= neg_q ? 16'(-qc_w) : qc_w;
			ST_OUT: begin
				if (load_out) begin
					pitch_q    <= p_q;
					rate_out_q <= rate_q;
					if (p_q > 16'sd0) begin
						dir_q     <= DIR_POS;
						payload_q <= {cfg.spd_pos, 24'd0, FRAME_CMD};
					end else if (p_q < 16'sd0) begin
						dir_q     <= DIR_NEG;
						payload_q <= {cfg.spd_neg, 24'd0, FRAME_CMD};
					end else begin
						dir_q     <= DIR_NONE;
						payload_q <= '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pe_q <= signed'(PITCH_LIMIT)) && (pe_q >= -signed'(PITCH_LIMIT)))
		else $error("kept pitch outside the saturation range");

	a_dir_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((dir_q == DIR_NONE) == (pitch_q == 16'sd0)))
		else $error("drive direction disagrees with pitch sign");

	a_cordic_count: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CORDIC) |-> (cnt_q < STEP_W'(STEPS)))
		else $error("CORDIC iteration count overran");

endmodule
